/* design/svpwm_pkg.sv */
// ----------------------------------------------------------------------------
// svpwm_pkg
// shared types, constants and helpers for the space vector pwm duty block
// ----------------------------------------------------------------------------
`default_nettype none

package svpwm_pkg;

  // default sample width (Q1.15)
  localparam int unsigned VALUE_WIDTH_DEF = 16;

  // front-to-back queue depth
  localparam int unsigned QUEUE_DEPTH = 2;

  // sector codes (sign code c*4+b*2+a)
  localparam logic [2:0] SEC_DEG0 = 3'd0;
  localparam logic [2:0] SEC_1    = 3'd1;
  localparam logic [2:0] SEC_2    = 3'd2;
  localparam logic [2:0] SEC_3    = 3'd3;
  localparam logic [2:0] SEC_4    = 3'd4;
  localparam logic [2:0] SEC_5    = 3'd5;
  localparam logic [2:0] SEC_6    = 3'd6;
  localparam logic [2:0] SEC_DEG7 = 3'd7;

  // round(sqrt(3)/2 * 2^f), worked out at elaboration
  function automatic longint unsigned sqrt3_half(input int unsigned f);
    longint unsigned n;
    longint unsigned r;
    longint unsigned b;
    n = longint'(3) << (2 * f - 2);
    r = 0;
    b = longint'(1) << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (n > r) r = r + 1;
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/svpwm_front.sv */
// ----------------------------------------------------------------------------
// svpwm_front
// forms y and z, classifies the sector and picks the two active times
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_front
  import svpwm_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          req_vld,
  input  wire logic signed [VALUE_WIDTH-1:0] alpha,
  input  wire logic signed [VALUE_WIDTH-1:0] beta,
  output logic                               out_vld,
  output logic signed [VALUE_WIDTH+1:0]      t1,
  output logic signed [VALUE_WIDTH+1:0]      t2,
  output logic        [2:0]                  code
);

  localparam int unsigned F  = VALUE_WIDTH - 1;
  localparam int unsigned PW = 2 * VALUE_WIDTH + 2;
  localparam int unsigned TW = VALUE_WIDTH + 2;
  localparam logic signed [VALUE_WIDTH:0] K = (VALUE_WIDTH+1)'(sqrt3_half(F));

  logic                          s1_vld_r, s1_vld_nxt;
  logic signed [PW-1:0]          ka_r, ka_nxt;
  logic signed [VALUE_WIDTH-1:0] b_r;
  logic signed [PW-1:0]          hb;
  logic signed [PW-1:0]          ysum, zsum;
  logic signed [TW-1:0]          x, y, z;
  logic [2:0]                    code_c;
  logic                          vld_r;
  logic signed [TW-1:0]          t1_r, t2_r, t1_nxt, t2_nxt;
  logic [2:0]                    code_r;

  // stage 1: multiply by sqrt(3)/2
  assign ka_nxt     = PW'(K) * PW'(alpha);
  assign s1_vld_nxt = req_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
    ka_r <= ka_nxt;
    b_r  <= beta;
  end

  // stage 2: y, z with round half up, sector code and active times
  assign hb   = PW'(b_r) <<< (F - 1);
  assign ysum = ka_r + hb + (PW'(1) <<< (F - 1));
  assign zsum = -ka_r + hb + (PW'(1) <<< (F - 1));
  assign x    = TW'(b_r);
  assign y    = TW'(ysum >>> F);
  assign z    = TW'(zsum >>> F);
  assign code_c = {y < 0, z < 0, x > 0};

  always_comb begin
    t1_nxt = '0;
    t2_nxt = '0;
    case (code_c)
      SEC_3:   begin t1_nxt = -z; t2_nxt = x;  end
      SEC_1:   begin t1_nxt = z;  t2_nxt = y;  end
      SEC_5:   begin t1_nxt = x;  t2_nxt = -y; end
      SEC_4:   begin t1_nxt = -x; t2_nxt = z;  end
      SEC_6:   begin t1_nxt = -y; t2_nxt = -z; end
      SEC_2:   begin t1_nxt = y;  t2_nxt = -x; end
      default: begin t1_nxt = '0; t2_nxt = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= s1_vld_r;
    end
    t1_r   <= t1_nxt;
    t2_r   <= t2_nxt;
    code_r <= code_c;
  end

  assign out_vld = vld_r;
  assign t1      = t1_r;
  assign t2      = t2_r;
  assign code    = code_r;

endmodule

`default_nettype wire

/* design/svpwm_queue.sv */
// ----------------------------------------------------------------------------
// svpwm_queue
// short request queue between the classifier and the duty back end
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_queue
  import svpwm_pkg::*;
#(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  output logic                  rd_vld,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  full
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign do_wr = wr_en && (cnt_r != (AW+1)'(DEPTH));
  assign do_rd = rd_en && (cnt_r != '0);

  // pointer and fill count update
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    if (do_rd) rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    if (do_wr && !do_rd) cnt_nxt = cnt_r + 1'b1;
    if (do_rd && !do_wr) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_wr) mem_r[wp_r] <= wr_data;
  end

  assign rd_vld  = (cnt_r != '0);
  assign rd_data = mem_r[rp_r];
  assign full    = (cnt_r == (AW+1)'(DEPTH));

endmodule

`default_nettype wire

/* design/svpwm_back.sv */
// ----------------------------------------------------------------------------
// svpwm_back
// overmodulation scaling by pipelined division, then duty mapping
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_back
  import svpwm_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_vld,
  input  wire logic signed [VALUE_WIDTH+1:0] t1,
  input  wire logic signed [VALUE_WIDTH+1:0] t2,
  input  wire logic        [2:0]             code,
  output logic                               res_vld,
  output logic [VALUE_WIDTH-1:0]             duty_a,
  output logic [VALUE_WIDTH-1:0]             duty_b,
  output logic [VALUE_WIDTH-1:0]             duty_c,
  output logic [2:0]                         sector,
  output logic                               scaled
);

  localparam int unsigned F  = VALUE_WIDTH - 1;
  localparam int unsigned TW = VALUE_WIDTH + 2;
  // quotient bits: scaled times never exceed one
  localparam int unsigned QB = VALUE_WIDTH;
  // dividend / remainder width
  localparam int unsigned RW = TW + 1;
  localparam int unsigned NS = QB + 1;
  localparam int unsigned DW = TW + 4;
  localparam logic signed [TW-1:0] ONE = TW'(1) <<< F;

  // pipeline stage contents
  logic           v_r    [NS];
  logic [2:0]     c_r    [NS];
  logic           sc_r   [NS];
  logic [TW-1:0]  s_r    [NS];
  logic [TW-1:0]  a1_r   [NS];
  logic [TW-1:0]  a2_r   [NS];
  logic [RW-1:0]  r1_r   [NS];
  logic [RW-1:0]  r2_r   [NS];
  logic [QB-1:0]  q1_r   [NS];
  logic [QB-1:0]  q2_r   [NS];

  logic signed [TW:0] sum;
  logic               over;
  logic [DW+F-1:0]    n1_0, n2_0;

  // stage 0: sum check, set up the restoring division
  // dividend (t<<F) + s/2; its bits above the quotient preload the remainder
  assign sum  = (TW+1)'(t1) + (TW+1)'(t2);
  assign over = (sum > (TW+1)'(ONE)) && (code != SEC_DEG0) && (code != SEC_DEG7);
  assign n1_0 = ((DW+F)'($unsigned(t1)) << F) + (DW+F)'($unsigned(sum) >> 1);
  assign n2_0 = ((DW+F)'($unsigned(t2)) << F) + (DW+F)'($unsigned(sum) >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_vld;
    end
    c_r[0]  <= code;
    sc_r[0] <= over;
    s_r[0]  <= TW'(sum);
    a1_r[0] <= t1;
    a2_r[0] <= t2;
    r1_r[0] <= RW'(n1_0 >> QB);
    r2_r[0] <= RW'(n2_0 >> QB);
    q1_r[0] <= '0;
    q2_r[0] <= '0;
  end

  // stages 1..QB: one quotient bit each
  // dividend value t*2^F + s/2 rebuilt each stage from the carried t and s
  for (genvar g = 1; g < NS; g++) begin : g_div
    logic [DW+F-1:0] n1, n2;
    logic [RW:0]     p1, p2;
    logic            b1, b2;
    localparam int unsigned BI = QB - g;
    assign n1 = ((DW+F)'(a1_r[g-1]) << F) + (DW+F)'(s_r[g-1] >> 1);
    assign n2 = ((DW+F)'(a2_r[g-1]) << F) + (DW+F)'(s_r[g-1] >> 1);
    assign p1 = {r1_r[g-1], n1[BI]};
    assign p2 = {r2_r[g-1], n2[BI]};
    assign b1 = p1 >= (RW+1)'(s_r[g-1]);
    assign b2 = p2 >= (RW+1)'(s_r[g-1]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else begin
        v_r[g] <= v_r[g-1];
      end
      c_r[g]  <= c_r[g-1];
      sc_r[g] <= sc_r[g-1];
      s_r[g]  <= s_r[g-1];
      a1_r[g] <= a1_r[g-1];
      a2_r[g] <= a2_r[g-1];
      r1_r[g] <= b1 ? RW'(p1 - (RW+1)'(s_r[g-1])) : RW'(p1);
      r2_r[g] <= b2 ? RW'(p2 - (RW+1)'(s_r[g-1])) : RW'(p2);
      q1_r[g] <= q1_r[g-1] | (QB'(b1) << BI);
      q2_r[g] <= q2_r[g-1] | (QB'(b2) << BI);
    end
  end

  // final stage: pick times, form duties, map phases
  logic signed [TW+1:0] e1, e2, da2, db2, dc2;
  logic [VALUE_WIDTH-1:0] da, db, dc, pa, pb, pc;
  logic                   scl;

  function automatic logic [VALUE_WIDTH-1:0] halve_clamp(input logic signed [TW+1:0] v);
    logic signed [TW+1:0] h;
    h = (v + (TW+2)'(1)) >>> 1;
    if (h < 0) return '0;
    if (h > (TW+2)'(ONE)) return VALUE_WIDTH'(ONE);
    return VALUE_WIDTH'(h);
  endfunction

  assign e1  = sc_r[NS-1] ? (TW+2)'(q1_r[NS-1]) : (TW+2)'(signed'(a1_r[NS-1]));
  assign e2  = sc_r[NS-1] ? (TW+2)'(q2_r[NS-1]) : (TW+2)'(signed'(a2_r[NS-1]));
  assign da2 = (TW+2)'(ONE) + e1 + e2;
  assign db2 = da2 - (e1 <<< 1);
  assign dc2 = db2 - (e2 <<< 1);
  assign da  = halve_clamp(da2);
  assign db  = halve_clamp(db2);
  assign dc  = halve_clamp(dc2);

  always_comb begin
    scl = sc_r[NS-1];
    case (c_r[NS-1])
      SEC_3:   begin pa = da; pb = db; pc = dc; end
      SEC_1:   begin pa = db; pb = da; pc = dc; end
      SEC_5:   begin pa = dc; pb = da; pc = db; end
      SEC_4:   begin pa = dc; pb = db; pc = da; end
      SEC_6:   begin pa = db; pb = dc; pc = da; end
      SEC_2:   begin pa = da; pb = dc; pc = db; end
      default: begin
        pa  = VALUE_WIDTH'(1) << (F - 1);
        pb  = VALUE_WIDTH'(1) << (F - 1);
        pc  = VALUE_WIDTH'(1) << (F - 1);
        scl = 1'b0;
      end
    endcase
  end

  logic                   vo_r;
  logic [VALUE_WIDTH-1:0] pa_r, pb_r, pc_r;
  logic [2:0]             co_r;
  logic                   so_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else begin
      vo_r <= v_r[NS-1];
    end
    pa_r <= pa;
    pb_r <= pb;
    pc_r <= pc;
    co_r <= c_r[NS-1];
    so_r <= scl;
  end

  assign res_vld = vo_r;
  assign duty_a  = pa_r;
  assign duty_b  = pb_r;
  assign duty_c  = pc_r;
  assign sector  = co_r;
  assign scaled  = so_r;

endmodule

`default_nettype wire

/* design/space_vector_pwm_duty.sv */
// ----------------------------------------------------------------------------
// space_vector_pwm_duty
// seven-segment space vector pwm duty calculator
// ----------------------------------------------------------------------------
// Usage: drive in_alpha/in_beta (signed Q1.F) with start high; a request is
// taken on any clock edge where busy is low. busy stays low in normal use:
// the block takes one request every cycle.
// A front end multiplies alpha by sqrt(3)/2, finds the sector and the two
// active times. A short queue feeds the back end, which divides both times
// by their sum bit by bit in a pipeline of VALUE_WIDTH stages (one quotient
// bit per stage), uses the quotients when the sum exceeds one, then maps
// centred duties onto the phases. Throughput is one request per cycle, set
// by the pipelined divider. out_valid marks each result for exactly one
// cycle; the receiver cannot stall, so results are never held. Reset clears
// all valid flags; no requests are lost or duplicated across the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module space_vector_pwm_duty
  import svpwm_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [VALUE_WIDTH-1:0] in_alpha,
  input  wire logic signed [VALUE_WIDTH-1:0] in_beta,
  output logic                               out_valid,
  output logic [VALUE_WIDTH-1:0]             out_duty_a,
  output logic [VALUE_WIDTH-1:0]             out_duty_b,
  output logic [VALUE_WIDTH-1:0]             out_duty_c,
  output logic [2:0]                         out_sector_code,
  output logic                               out_was_scaled
);

  localparam int unsigned TW = VALUE_WIDTH + 2;
  localparam int unsigned QW = 2 * TW + 3;

  logic                 acc;
  logic                 f_vld;
  logic signed [TW-1:0] f_t1, f_t2;
  logic [2:0]           f_code;
  logic                 q_vld, q_full;
  logic [QW-1:0]        q_data;

  // back end never stalls, so the queue drains every cycle
  assign busy = q_full;
  assign acc  = start && !busy;

  svpwm_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .req_vld (acc),
    .alpha   (in_alpha),
    .beta    (in_beta),
    .out_vld (f_vld),
    .t1      (f_t1),
    .t2      (f_t2),
    .code    (f_code)
  );

  svpwm_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (f_vld),
    .wr_data ({f_t1, f_t2, f_code}),
    .rd_en   (1'b1),
    .rd_vld  (q_vld),
    .rd_data (q_data),
    .full    (q_full)
  );

  svpwm_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (q_vld),
    .t1      (q_data[QW-1 -: TW]),
    .t2      (q_data[TW+2 -: TW]),
    .code    (q_data[2:0]),
    .res_vld (out_valid),
    .duty_a  (out_duty_a),
    .duty_b  (out_duty_b),
    .duty_c  (out_duty_c),
    .sector  (out_sector_code),
    .scaled  (out_was_scaled)
  );

  // degenerate sectors never report scaling
  a_deg_noscale: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_sector_code == SEC_DEG0 || out_sector_code == SEC_DEG7)
      |-> !out_was_scaled)
    else $error("scaling flagged on degenerate sector");

  // duties never exceed one
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_duty_a <= (VALUE_WIDTH'(1) << (VALUE_WIDTH-1)))
               && (out_duty_b <= (VALUE_WIDTH'(1) << (VALUE_WIDTH-1)))
               && (out_duty_c <= (VALUE_WIDTH'(1) << (VALUE_WIDTH-1))))
    else $error("duty above full scale");

  // queue never overflows since the back end drains every cycle
  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("queue backed up");

endmodule

`default_nettype wire

/* test/space_vector_pwm_duty_tb.sv */
// ----------------------------------------------------------------------------
// space_vector_pwm_duty_tb
// drives alpha/beta vectors into the duty calculator and checks every
// result against an in-bench sector/duty predictor, in order of issue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module space_vector_pwm_duty_tb;
  import svpwm_pkg::*;

  localparam int W = VALUE_WIDTH_DEF;
  localparam int F = W - 1;
  localparam int LATENCY = W + 5;
  localparam int N_RANDOM = 1430;
  localparam longint CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [W-1:0] duty_a;
    logic [W-1:0] duty_b;
    logic [W-1:0] duty_c;
    logic [2:0]   sector;
    logic         scaled;
  } duty_set_t;

  typedef struct {
    logic signed [W-1:0] alpha;
    logic signed [W-1:0] beta;
    bit                  typed;
    duty_set_t           duties;
  } vec_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [W-1:0] in_alpha = '0;
  logic signed [W-1:0] in_beta = '0;
  logic out_valid;
  logic [W-1:0] out_duty_a, out_duty_b, out_duty_c;
  logic [2:0] out_sector_code;
  logic out_was_scaled;

  duty_set_t pending_duties[$];
  int  n_fail = 0;
  int  n_checked = 0;
  int  n_scaled = 0;
  int  sector_seen[8];
  longint n_cycles = 0;
  longint root3_k;

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  space_vector_pwm_duty #(.VALUE_WIDTH(W)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_alpha(in_alpha), .in_beta(in_beta), .out_valid(out_valid),
    .out_duty_a(out_duty_a), .out_duty_b(out_duty_b), .out_duty_c(out_duty_c),
    .out_sector_code(out_sector_code), .out_was_scaled(out_was_scaled)
  );

  // round(sqrt(3)/2 * 2^F) by bisection on the square
  function automatic longint root3_half();
    longint target, lo, hi, mid;
    target = longint'(3) << (2 * F - 2);
    lo = 0;
    hi = longint'(1) << F;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (mid * mid <= target) lo = mid;
      else hi = mid;
    end
    // round: pick lo+1 when target exceeds lo*(lo+1)
    if (target - lo * lo > lo) lo = lo + 1;
    return lo;
  endfunction

  function automatic longint floor_div2p(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic [W-1:0] halve_sat(longint twice);
    longint v;
    v = (twice + 1) >>> 1;
    if (v < 0) v = 0;
    if (v > (longint'(1) << F)) v = longint'(1) << F;
    return v[W-1:0];
  endfunction

  // expected duties for one vector
  function automatic duty_set_t predict_duties(logic signed [W-1:0] a_in,
                                               logic signed [W-1:0] b_in);
    longint one, hl, al, be, ka, x, y, z, t1, t2, total, da2, db2, dc2;
    logic [W-1:0] da, db, dc;
    logic [2:0] sec;
    duty_set_t r;
    one = longint'(1) << F;
    hl = longint'(1) << (F - 1);
    al = longint'(a_in);
    be = longint'(b_in);
    ka = root3_k * al;
    x = be;
    y = floor_div2p(ka + be * hl + hl, F);
    z = floor_div2p(-ka + be * hl + hl, F);
    sec = {y < 0, z < 0, x > 0};
    t1 = 0;
    t2 = 0;
    r.scaled = 1'b0;
    case (sec)
      SEC_3: begin t1 = -z; t2 = x; end
      SEC_1: begin t1 = z; t2 = y; end
      SEC_5: begin t1 = x; t2 = -y; end
      SEC_4: begin t1 = -x; t2 = z; end
      SEC_6: begin t1 = -y; t2 = -z; end
      SEC_2: begin t1 = y; t2 = -x; end
      default: ;
    endcase
    total = t1 + t2;
    if (total > one) begin
      t1 = ((t1 << F) + (total >> 1)) / total;
      t2 = ((t2 << F) + (total >> 1)) / total;
      r.scaled = 1'b1;
    end
    da2 = one + t1 + t2;
    db2 = da2 - 2 * t1;
    dc2 = db2 - 2 * t2;
    da = halve_sat(da2);
    db = halve_sat(db2);
    dc = halve_sat(dc2);
    case (sec)
      SEC_3: {r.duty_a, r.duty_b, r.duty_c} = {da, db, dc};
      SEC_1: {r.duty_a, r.duty_b, r.duty_c} = {db, da, dc};
      SEC_5: {r.duty_a, r.duty_b, r.duty_c} = {dc, da, db};
      SEC_4: {r.duty_a, r.duty_b, r.duty_c} = {dc, db, da};
      SEC_6: {r.duty_a, r.duty_b, r.duty_c} = {db, dc, da};
      SEC_2: {r.duty_a, r.duty_b, r.duty_c} = {da, dc, db};
      default: begin
        r.duty_a = hl[W-1:0];
        r.duty_b = hl[W-1:0];
        r.duty_c = hl[W-1:0];
        r.scaled = 1'b0;
      end
    endcase
    r.sector = sec;
    return r;
  endfunction

  // result checker, sampled at the edge that accepts the result
  always @(posedge clk) begin
    duty_set_t got, want;
    n_cycles <= n_cycles + 1;
    if (rst_n && out_valid) begin
      got = '{out_duty_a, out_duty_b, out_duty_c, out_sector_code, out_was_scaled};
      if (pending_duties.size() == 0) begin
        n_fail++;
        if (n_fail <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_duties.pop_front();
        n_checked++;
        if (got.scaled) n_scaled++;
        sector_seen[got.sector]++;
        if (got !== want) begin
          n_fail++;
          if (n_fail <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", n_cycles);
      $display("space_vector_pwm_duty_tb: errors");
      $finish;
    end
  end

  // one request; gap applies idle cycles before it
  task automatic send_request(logic signed [W-1:0] a, logic signed [W-1:0] b,
                              duty_set_t want, int gap);
    repeat (gap) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_alpha <= a;
    in_beta <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_duties.push_back(want);
  endtask

  vec_row_t directed_rows[$];

  function automatic vec_row_t mk_row(int a, int b);
    vec_row_t r;
    r.alpha = W'(a);
    r.beta = W'(b);
    r.typed = 1'b0;
    r.duties = '0;
    return r;
  endfunction

  function automatic vec_row_t mk_typed(int a, int b, duty_set_t d);
    vec_row_t r;
    r = mk_row(a, b);
    r.typed = 1'b1;
    r.duties = d;
    return r;
  endfunction

  initial begin
    logic signed [W-1:0] a, b;
    int gap, mode, mag;
    duty_set_t want;
    root3_k = root3_half();

    // directed table: zero vector degenerate, extremes, each sector
    directed_rows.push_back(mk_typed(0, 0, '{16'h4000, 16'h4000, 16'h4000, SEC_DEG0, 1'b0}));
    directed_rows.push_back(mk_row(32767, 0));
    directed_rows.push_back(mk_row(-32768, 0));
    directed_rows.push_back(mk_row(0, 32767));
    directed_rows.push_back(mk_row(0, -32768));
    directed_rows.push_back(mk_row(32767, 32767));
    directed_rows.push_back(mk_row(-32768, -32768));
    directed_rows.push_back(mk_row(32767, -32768));
    directed_rows.push_back(mk_row(-32768, 32767));
    directed_rows.push_back(mk_row(1, 0));
    directed_rows.push_back(mk_row(-1, 0));
    directed_rows.push_back(mk_row(0, 1));
    directed_rows.push_back(mk_row(0, -1));
    directed_rows.push_back(mk_row(8000, 3000));
    directed_rows.push_back(mk_row(1000, 12000));
    directed_rows.push_back(mk_row(-8000, 3000));
    directed_rows.push_back(mk_row(-8000, -3000));
    directed_rows.push_back(mk_row(1000, -12000));
    directed_rows.push_back(mk_row(8000, -3000));
    directed_rows.push_back(mk_row(-1, -1));
    directed_rows.push_back(mk_row(20000, 20000));
    directed_rows.push_back(mk_row(-21845, 12000));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      want = directed_rows[i].typed ? directed_rows[i].duties
                                    : predict_duties(directed_rows[i].alpha,
                                                     directed_rows[i].beta);
      send_request(directed_rows[i].alpha, directed_rows[i].beta, want, 0);
    end

    // drain hold-off: let every expected result land first
    start <= 1'b0;
    @(posedge clk);
    while (pending_duties.size() != 0) @(posedge clk);

    // random vectors: mixed magnitudes, full-range noise, bursty gaps
    for (int n = 0; n < N_RANDOM; n++) begin
      mode = $urandom_range(0, 9);
      if (mode < 3) begin
        a = W'($urandom);
        b = W'($urandom);
      end else if (mode < 8) begin
        mag = $urandom_range(1, 5) == 1 ? 32767 : $urandom_range(100, 24000);
        a = W'($signed($urandom_range(0, 2 * mag)) - mag);
        b = W'($signed($urandom_range(0, 2 * mag)) - mag);
      end else begin
        a = W'($signed($urandom_range(0, 8)) - 4);
        b = W'($signed($urandom_range(0, 8)) - 4);
      end
      gap = (n < N_RANDOM - 200 && $urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
      send_request(a, b, predict_duties(a, b), gap);
    end
    start <= 1'b0;

    while (pending_duties.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);

    $display("checked %0d results, %0d overmodulated, zero-vector hits %0d",
             n_checked, n_scaled, sector_seen[SEC_DEG0]);
    $display("sectors 1..6 seen: %0d %0d %0d %0d %0d %0d", sector_seen[1],
             sector_seen[2], sector_seen[3], sector_seen[4], sector_seen[5],
             sector_seen[6]);
    if (n_fail == 0) begin
      $display("space_vector_pwm_duty_tb: clean");
    end else begin
      $display("%0d failures", n_fail);
      $display("space_vector_pwm_duty_tb: errors");
    end
    $finish;
  end

endmodule
